>>> rtl/crs_pkg.sv
// ============================================================================
// crs_pkg
// Shared types and constants of the committed range interval set.
// ============================================================================
package crs_pkg;

    localparam int unsigned MaxRangesDefault = 64;
    localparam int unsigned OffW  = 48;
    localparam int unsigned LenW  = 49;
    localparam int unsigned MaskW = 16;

    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusInvalid = 2'd1;
    localparam logic [1:0] StatusFull    = 2'd2;

    localparam logic CmdQuery = 1'b0;
    localparam logic CmdAdd   = 1'b1;

    localparam logic [1:0] RegRegionSize   = 2'd0;
    localparam logic [1:0] RegPageMask     = 2'd1;
    localparam logic [1:0] RegAllCommitted = 2'd2;

    localparam logic [MaskW-1:0] PageMaskReset = 16'd4095;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,    // issue table read at scan index
        ST_SCAN_CHK,   // examine entry
        ST_ABS_RD,     // issue read of next entry while absorbing
        ST_ABS_CHK,
        ST_CMP_RD,     // compact: read entry k
        ST_CMP_WR,     // compact: write entry k - gone
        ST_INS_RD,     // insert shift: read entry j - 1
        ST_INS_WR,     // insert shift: write entry j
        ST_FINAL_WR,   // write the merged or new entry
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic rd;         // read table at r_addr
        logic set_i;      // i <- addr
        logic addr_zero;
        logic addr_inc;
        logic addr_dec;
        logic addr_from_i1;   // addr <- i + 1
        logic addr_from_cnt;  // addr <- count
        logic mark_j;         // j <- addr
        logic addr_from_j;    // addr <- j (compact start)
        logic wr_shift_down;  // write rd data at addr - gone
        logic wr_shift_up;    // write rd data at addr + 1
        logic wr_final;       // write entry at i with lo/hi
        logic lo_update;      // start[i] <- lo if lower
        logic hi_absorb;      // hi <- max(hi, end)
        logic cnt_sub_gone;
        logic cnt_inc;
        logic res_scan;       // produce result from entry / region
        logic res_set;
        logic [1:0] res_status;
        logic res_from_entry;
        logic res_commit;
        logic res_hit;        // use end (else start) when from entry
        logic out_valid;
    } t_cmd;

    typedef struct packed {
        logic cmd;
        logic bad;         // validation failed
        logic all_comm;
        logic addr_lt_cnt;
        logic addr_gt_i;   // for insert loop j > i
        logic st_gt_hi;    // start > hi (query: start > off)
        logic en_lt_lo;    // end < lo
        logic en_gt_off;   // end > off
        logic en_lt_hi;
        logic full;
        logic absorbed;    // j > i + 1
    } t_sts;

endpackage

>>> rtl/crs_ram.sv
// ============================================================================
// crs_ram
// Generic RAM with one write port, one read port and registered read.
// ============================================================================
module crs_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/crs_datapath.sv
// ============================================================================
// crs_datapath
// Table storage, scan registers, validation and result register.
// ============================================================================
module crs_datapath #(
    parameter int unsigned MaxRanges = crs_pkg::MaxRangesDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  crs_pkg::t_cmd                  i_ctl,
    output crs_pkg::t_sts                  o_sts,
    input  logic                           i_in_cmd,
    input  logic [crs_pkg::OffW-1:0]       i_in_offset,
    input  logic [crs_pkg::LenW-1:0]       i_in_length,
    input  logic [crs_pkg::LenW-1:0]       i_region_size,
    input  logic [crs_pkg::MaskW-1:0]      i_align_mask,
    input  logic                           i_all_committed,
    output logic [1:0]                     o_status,
    output logic                           o_committed,
    output logic [crs_pkg::LenW-1:0]       o_run_size
);
    localparam int unsigned AW = $clog2(MaxRanges);
    localparam int unsigned CW = $clog2(MaxRanges + 1);
    localparam int unsigned EW = crs_pkg::OffW + crs_pkg::LenW;

    logic                     r_cmd;
    logic [crs_pkg::OffW-1:0] r_off;
    logic [crs_pkg::LenW-1:0] r_hi;
    logic                     r_bad;
    logic [CW-1:0]            r_addr, r_i, r_j, r_cnt;
    logic [crs_pkg::OffW-1:0] r_newlo;   // start to write at i
    logic [1:0]               r_status;
    logic                     r_comm;
    logic [crs_pkg::LenW-1:0] r_run;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [crs_pkg::OffW-1:0] e_st;
    logic [crs_pkg::LenW-1:0] e_en;
    logic [CW-1:0] gone;
    logic [crs_pkg::LenW-1:0] off_x, len_rem;
    logic bad_in;

    crs_ram #(.Width(EW), .Depth(MaxRanges)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign e_st  = rdata[EW-1 -: crs_pkg::OffW];
    assign e_en  = rdata[crs_pkg::LenW-1:0];
    assign gone  = r_j - r_i - CW'(1);
    assign raddr = r_addr[AW-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = r_addr[AW-1:0];
        wdata = rdata;
        if (i_ctl.wr_shift_down) begin
            we    = 1'b1;
            waddr = AW'(r_addr - gone);
        end else if (i_ctl.wr_shift_up) begin
            we    = 1'b1;
            waddr = AW'(r_addr + CW'(1));
        end else if (i_ctl.wr_final) begin
            we    = 1'b1;
            waddr = r_i[AW-1:0];
            wdata = {r_newlo, r_hi};
        end
    end

    // validation of the incoming item
    assign off_x   = {1'b0, i_in_offset};
    assign len_rem = i_region_size - off_x;
    always_comb begin
        bad_in = ((off_x[crs_pkg::MaskW-1:0] & i_align_mask) != '0) ||
                 (off_x >= i_region_size);
        if (i_in_cmd == crs_pkg::CmdAdd) begin
            bad_in = bad_in ||
                     ((i_in_length[crs_pkg::MaskW-1:0] & i_align_mask) != '0) ||
                     (i_in_length == '0) ||
                     (!(off_x >= i_region_size) && i_in_length > len_rem);
        end
    end

    assign o_sts.cmd         = r_cmd;
    assign o_sts.bad         = r_bad;
    assign o_sts.all_comm    = i_all_committed;
    assign o_sts.addr_lt_cnt = r_addr < r_cnt;
    assign o_sts.addr_gt_i   = r_addr > r_i;
    assign o_sts.st_gt_hi    = (r_cmd == crs_pkg::CmdAdd) ? ({1'b0, e_st} > r_hi)
                                                          : (e_st > r_off);
    assign o_sts.en_lt_lo    = e_en < {1'b0, r_off};
    assign o_sts.en_gt_off   = e_en > {1'b0, r_off};
    assign o_sts.en_lt_hi    = e_en < r_hi;
    assign o_sts.full        = r_cnt >= CW'(MaxRanges);
    assign o_sts.absorbed    = r_j > r_i + CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_in_cmd;
            r_off   <= i_in_offset;
            r_newlo <= i_in_offset;
            r_hi    <= off_x + i_in_length;
            r_bad   <= bad_in;
        end
        if (i_ctl.set_i) begin
            r_i <= r_addr;
        end
        if (i_ctl.mark_j) begin
            r_j <= r_addr;
        end
        if (i_ctl.lo_update) begin
            // keep the stored start unless the new range reaches lower
            r_newlo <= (e_st < r_off) ? e_st : r_off;
        end
        if (i_ctl.hi_absorb && e_en > r_hi) begin
            r_hi <= e_en;
        end
        priority if (i_ctl.addr_zero)     r_addr <= '0;
        else if (i_ctl.addr_inc)          r_addr <= r_addr + CW'(1);
        else if (i_ctl.addr_dec)          r_addr <= r_addr - CW'(1);
        else if (i_ctl.addr_from_i1)      r_addr <= r_i + CW'(1);
        else if (i_ctl.addr_from_cnt)     r_addr <= r_cnt;
        else if (i_ctl.addr_from_j)       r_addr <= r_j;
        else                              r_addr <= r_addr;
        if (i_ctl.res_set) begin
            r_status <= i_ctl.res_status;
            r_comm   <= i_ctl.res_commit;
            if (!i_ctl.res_scan) begin
                r_run <= '0;
            end else if (i_ctl.res_from_entry) begin
                r_run <= (i_ctl.res_hit ? e_en : {1'b0, e_st}) - {1'b0, r_off};
            end else begin
                r_run <= i_region_size - {1'b0, r_off};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.cnt_sub_gone) begin
            r_cnt <= r_cnt - gone;
        end else if (i_ctl.cnt_inc) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_status    = r_status;
    assign o_committed = r_comm;
    assign o_run_size  = r_run;
endmodule

>>> rtl/crs_ctrl.sv
// ============================================================================
// crs_ctrl
// Sequencer for scan, absorb, compaction and insertion passes.
// ============================================================================
module crs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output crs_pkg::t_cmd o_ctl,
    input  crs_pkg::t_sts i_sts
);
    crs_pkg::t_state r_state, n_state;
    logic r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            crs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load      = 1'b1;
                    o_ctl.addr_zero = 1'b1;
                    n_state         = crs_pkg::ST_SCAN_RD;
                end
            end
            crs_pkg::ST_SCAN_RD: begin
                o_ctl.res_set = 1'b1;
                o_ctl.set_i   = 1'b1;
                if (i_sts.bad) begin
                    o_ctl.res_status = crs_pkg::StatusInvalid;
                    n_state          = crs_pkg::ST_DONE;
                end else if (i_sts.all_comm) begin
                    o_ctl.res_status = crs_pkg::StatusOk;
                    o_ctl.res_scan   = (i_sts.cmd == crs_pkg::CmdQuery);
                    o_ctl.res_commit = (i_sts.cmd == crs_pkg::CmdQuery);
                    n_state          = crs_pkg::ST_DONE;
                end else if (!i_sts.addr_lt_cnt) begin
                    // end of table
                    if (i_sts.cmd == crs_pkg::CmdQuery) begin
                        o_ctl.res_scan = 1'b1;
                        n_state        = crs_pkg::ST_DONE;
                    end else if (i_sts.full) begin
                        o_ctl.res_status = crs_pkg::StatusFull;
                        n_state          = crs_pkg::ST_DONE;
                    end else begin
                        o_ctl.addr_from_cnt = 1'b1;
                        n_state             = crs_pkg::ST_INS_RD;
                    end
                end else begin
                    o_ctl.res_set = 1'b0;
                    o_ctl.rd      = 1'b1;
                    n_state       = crs_pkg::ST_SCAN_CHK;
                end
            end
            crs_pkg::ST_SCAN_CHK: begin
                if (i_sts.cmd == crs_pkg::CmdQuery) begin
                    if (i_sts.st_gt_hi || i_sts.en_gt_off) begin
                        o_ctl.res_set        = 1'b1;
                        o_ctl.res_scan       = 1'b1;
                        o_ctl.res_from_entry = 1'b1;
                        o_ctl.res_hit        = !i_sts.st_gt_hi;
                        o_ctl.res_commit     = !i_sts.st_gt_hi;
                        n_state              = crs_pkg::ST_DONE;
                    end else begin
                        o_ctl.addr_inc = 1'b1;
                        n_state        = crs_pkg::ST_SCAN_RD;
                    end
                end else if (i_sts.st_gt_hi) begin
                    o_ctl.set_i = 1'b1;
                    o_ctl.res_set = 1'b1;
                    if (i_sts.full) begin
                        o_ctl.res_status = crs_pkg::StatusFull;
                        n_state          = crs_pkg::ST_DONE;
                    end else begin
                        o_ctl.addr_from_cnt = 1'b1;
                        n_state             = crs_pkg::ST_INS_RD;
                    end
                end else if (i_sts.en_lt_lo) begin
                    o_ctl.addr_inc = 1'b1;
                    n_state        = crs_pkg::ST_SCAN_RD;
                end else begin
                    // merge into entry i
                    o_ctl.set_i     = 1'b1;
                    o_ctl.lo_update = 1'b1;
                    o_ctl.res_set   = 1'b1;
                    if (i_sts.en_lt_hi) begin
                        o_ctl.addr_inc = 1'b1;
                        n_state        = crs_pkg::ST_ABS_RD;
                    end else begin
                        // stored end already covers hi
                        o_ctl.hi_absorb = 1'b1;
                        n_state         = crs_pkg::ST_FINAL_WR;
                    end
                end
            end
            crs_pkg::ST_ABS_RD: begin
                if (i_sts.addr_lt_cnt) begin
                    o_ctl.rd = 1'b1;
                    n_state  = crs_pkg::ST_ABS_CHK;
                end else begin
                    o_ctl.mark_j = 1'b1;
                    n_state      = crs_pkg::ST_CMP_RD;
                end
            end
            crs_pkg::ST_ABS_CHK: begin
                if (i_sts.st_gt_hi) begin
                    o_ctl.mark_j = 1'b1;
                    n_state      = crs_pkg::ST_CMP_RD;
                end else begin
                    o_ctl.hi_absorb = 1'b1;
                    o_ctl.addr_inc  = 1'b1;
                    n_state         = crs_pkg::ST_ABS_RD;
                end
            end
            crs_pkg::ST_CMP_RD: begin
                if (!i_sts.absorbed) begin
                    n_state = crs_pkg::ST_FINAL_WR;
                end else if (i_sts.addr_lt_cnt) begin
                    o_ctl.rd = 1'b1;
                    n_state  = crs_pkg::ST_CMP_WR;
                end else begin
                    o_ctl.cnt_sub_gone = 1'b1;
                    n_state            = crs_pkg::ST_FINAL_WR;
                end
            end
            crs_pkg::ST_CMP_WR: begin
                o_ctl.wr_shift_down = 1'b1;
                o_ctl.addr_inc      = 1'b1;
                n_state             = crs_pkg::ST_CMP_RD;
            end
            crs_pkg::ST_INS_RD: begin
                if (i_sts.addr_gt_i) begin
                    o_ctl.addr_dec = 1'b1;
                    n_state        = crs_pkg::ST_INS_WR;
                end else begin
                    o_ctl.cnt_inc = 1'b1;
                    n_state       = crs_pkg::ST_FINAL_WR;
                end
            end
            crs_pkg::ST_INS_WR: begin
                // addr now j - 1, read pending on the address set in ST_INS_RD
                o_ctl.rd = 1'b1;
                n_state  = crs_pkg::ST_INS_WR;
                if (r_rd_ok) begin
                    o_ctl.wr_shift_up = 1'b1;
                    n_state           = crs_pkg::ST_INS_RD;
                end
            end
            crs_pkg::ST_FINAL_WR: begin
                o_ctl.wr_final = 1'b1;
                n_state        = crs_pkg::ST_DONE;
            end
            crs_pkg::ST_DONE: begin
                if (i_out_ready) begin
                    n_state = crs_pkg::ST_IDLE;
                end
            end
            default: n_state = crs_pkg::ST_IDLE;
        endcase
    end

    // insert shift: ST_INS_WR issues the read, then writes once r_rd_ok shows the data is back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= (r_state == crs_pkg::ST_INS_WR) && !r_rd_ok;
        end
    end

    assign o_out_valid = (r_state == crs_pkg::ST_DONE);

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("ready while result pending");
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped");
    a_one_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_ctl.wr_shift_down, o_ctl.wr_shift_up, o_ctl.wr_final}) <= 1)
        else $error("write conflict");
`endif
endmodule

>>> rtl/committed_range_interval_set.sv
// ============================================================================
// committed_range_interval_set
// Sorted table of disjoint committed byte ranges with merge and query.
// ============================================================================
// One command at a time. Each command gives one result, and a result that
// waits holds the input off. A query scans the entries in order; an add
// scans, then absorbs or compacts entries through the table RAM, reading
// and then writing each entry, or shifts them up one by one for an insert.
// Each step waits for the registered read of the table RAM. Registers:
// region_size at 0x00, the alignment mask (page size minus one) at 0x08,
// all_committed at 0x10 (64-bit data).
module committed_range_interval_set #(
    parameter int unsigned MaxRanges = crs_pkg::MaxRangesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [47:0] i_offset,
    input  logic [48:0] i_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_committed,
    output logic [48:0] o_run_size,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [48:0] r_region_size;
    logic [15:0] r_align_mask;
    logic        r_all_committed;
    logic [1:0]  reg_idx;
    crs_pkg::t_cmd ctl;
    crs_pkg::t_sts sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_size   <= '0;
            r_align_mask    <= crs_pkg::PageMaskReset;
            r_all_committed <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                crs_pkg::RegRegionSize:   r_region_size   <= pwdata[48:0];
                crs_pkg::RegPageMask:     r_align_mask    <= pwdata[15:0];
                crs_pkg::RegAllCommitted: r_all_committed <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            crs_pkg::RegRegionSize:   prdata = {15'd0, r_region_size};
            crs_pkg::RegPageMask:     prdata = {48'd0, r_align_mask};
            crs_pkg::RegAllCommitted: prdata = {63'd0, r_all_committed};
            default:                  prdata = '0;
        endcase
    end

    crs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .o_out_valid(o_valid),
        .i_out_ready(i_ready),
        .o_ctl      (ctl),
        .i_sts      (sts)
    );

    crs_datapath #(.MaxRanges(MaxRanges)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_in_cmd       (i_cmd),
        .i_in_offset    (i_offset),
        .i_in_length    (i_length),
        .i_region_size  (r_region_size),
        .i_align_mask   (r_align_mask),
        .i_all_committed(r_all_committed),
        .o_status       (o_status),
        .o_committed    (o_committed),
        .o_run_size     (o_run_size)
    );
endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for committed_range_interval_set
// Drives add and query commands through the valid/ready input, writes the
// registers over APB between phases, and checks every result beat against
// a cycle-free model of the sorted range table.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned TableDepth = 64;
    localparam int unsigned IdleLimit  = 5000;
    localparam logic [63:0] RegionMax  = 64'h1_0000_0000_0000;

    typedef struct {
        logic [1:0]  status;
        logic        committed;
        logic [48:0] run_size;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = 1'b0;
    logic [47:0] i_offset = '0;
    logic [48:0] i_length = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_committed;
    logic [48:0] o_run_size;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // model state
    logic [47:0] span_lo [TableDepth];
    logic [48:0] span_hi [TableDepth];
    int unsigned span_count = 0;
    logic [63:0] cfg_region = 0;
    logic [63:0] cfg_mask = 64'd4095;
    logic        cfg_all = 1'b0;

    t_result     pending_results[$];
    int          mismatches = 0;
    int          burst_left = 0;
    int unsigned idle_cycles = 0;
    int          hold_len = 0;
    logic        hold_tog = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_cnt = 0;
    int          ready_mode = 0;
    int          mode_cnt = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    committed_range_interval_set u_top (.*);

    // merge [lo, hi) into the table, or insert it in order
    function automatic logic [1:0] merge_span(input logic [63:0] lo, input logic [63:0] hi);
        int unsigned i, j, k, gone;
        logic [63:0] top;
        top = hi;
        for (i = 0; i < span_count; i++) begin
            if (span_lo[i] > top) break;
            if (span_hi[i] < lo) continue;
            if (span_lo[i] > lo) span_lo[i] = lo[47:0];
            if (span_hi[i] < top) begin
                for (j = i + 1; j < span_count; j++) begin
                    if (span_lo[j] > top) break;
                    if (span_hi[j] > top) top = {15'd0, span_hi[j]};
                end
                if (j > i + 1) begin
                    gone = j - (i + 1);
                    for (k = j; k < span_count; k++) begin
                        span_lo[k - gone] = span_lo[k];
                        span_hi[k - gone] = span_hi[k];
                    end
                    span_count -= gone;
                end
                span_hi[i] = top[48:0];
            end
            return crs_pkg::StatusOk;
        end
        if (span_count >= TableDepth) return crs_pkg::StatusFull;
        for (j = span_count; j > i; j--) begin
            span_lo[j] = span_lo[j - 1];
            span_hi[j] = span_hi[j - 1];
        end
        span_lo[i] = lo[47:0];
        span_hi[i] = top[48:0];
        span_count++;
        return crs_pkg::StatusOk;
    endfunction

    function automatic t_result predict_result(input logic c, input logic [47:0] off,
                                               input logic [48:0] len);
        t_result r;
        logic [63:0] o, l, run;
        logic hit, found;
        o = {16'd0, off};
        l = {15'd0, len};
        r.status = crs_pkg::StatusOk;
        r.committed = 1'b0;
        r.run_size = '0;
        if (c == crs_pkg::CmdAdd) begin
            if ((l & cfg_mask) != 0 || (o & cfg_mask) != 0 || o >= cfg_region ||
                    l == 0 || l > cfg_region - o) begin
                r.status = crs_pkg::StatusInvalid;
            end else if (!cfg_all) begin
                r.status = merge_span(o, o + l);
            end
        end else if ((o & cfg_mask) != 0 || o >= cfg_region) begin
            r.status = crs_pkg::StatusInvalid;
        end else if (cfg_all) begin
            r.committed = 1'b1;
            r.run_size = 49'(cfg_region - o);
        end else begin
            found = 1'b0;
            hit = 1'b0;
            run = 0;
            for (int unsigned i = 0; i < span_count && !found; i++) begin
                if ({16'd0, span_lo[i]} > o) begin
                    run = {16'd0, span_lo[i]} - o;
                    found = 1'b1;
                end else if ({15'd0, span_hi[i]} > o) begin
                    run = {15'd0, span_hi[i]} - o;
                    hit = 1'b1;
                    found = 1'b1;
                end
            end
            if (!found) run = cfg_region - o;
            r.committed = hit;
            r.run_size = run[48:0];
        end
        return r;
    endfunction

    // offer one command beat; returns in the time step of its acceptance
    task automatic send_cmd(input logic c, input logic [47:0] off, input logic [48:0] len);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_cmd    <= c;
        i_offset <= off;
        i_length <= len;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(predict_result(c, off, len));
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        drain();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            crs_pkg::RegRegionSize:   cfg_region = {15'd0, value[48:0]};
            crs_pkg::RegPageMask:     cfg_mask = {48'd0, value[15:0]};
            crs_pkg::RegAllCommitted: cfg_all = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [63:0] region, input logic [63:0] mask,
                              input logic all_on);
        write_reg(crs_pkg::RegRegionSize, region);
        write_reg(crs_pkg::RegPageMask, mask);
        write_reg(crs_pkg::RegAllCommitted, {63'd0, all_on});
    endtask

    task automatic add_pages(input logic [63:0] first, input logic [63:0] count);
        logic [63:0] pg;
        pg = cfg_mask + 1;
        send_cmd(crs_pkg::CmdAdd, 48'(first * pg), 49'(count * pg));
    endtask

    task automatic query_page(input logic [63:0] page);
        send_cmd(crs_pkg::CmdQuery, 48'(page * (cfg_mask + 1)), '0);
    endtask

    task automatic test_reset_values;
        // region is empty after reset: everything is rejected
        query_page(0);
        add_pages(0, 1);
        send_cmd(crs_pkg::CmdAdd, 48'd5, 49'd4096);
        drain();
    endtask

    task automatic test_table_full;
        set_config(512 * 4096, 4095, 1'b0);
        for (int k = 0; k < TableDepth; k++) add_pages(64'(2 * k), 1);
        add_pages(200, 1);
        add_pages(1, 1);
        add_pages(300, 1);
        add_pages(400, 1);
        query_page(2);
        query_page(127);
        add_pages(0, 512);
        query_page(511);
        drain();
    endtask

    task automatic test_edges;
        set_config(64 * 4096, 4095, 1'b0);
        send_cmd(crs_pkg::CmdAdd, 48'h1000, 49'h0800);
        send_cmd(crs_pkg::CmdAdd, 48'h0800, 49'h1000);
        add_pages(3, 0);
        add_pages(64, 1);
        add_pages(60, 5);
        add_pages(63, 1);
        add_pages(10, 2);
        add_pages(20, 2);
        add_pages(12, 8);
        add_pages(8, 1);
        add_pages(30, 2);
        add_pages(5, 30);
        query_page(0);
        query_page(5);
        query_page(40);
        query_page(63);
        query_page(64);
        send_cmd(crs_pkg::CmdQuery, 48'h123, '0);
        drain();
    endtask

    task automatic test_all_committed;
        set_config(64 * 4096, 4095, 1'b1);
        query_page(0);
        query_page(50);
        add_pages(45, 3);
        add_pages(60, 9);
        write_reg(crs_pkg::RegAllCommitted, 64'd0);
        query_page(46);
        drain();
    endtask

    task automatic test_wide_fields;
        set_config(RegionMax, 0, 1'b0);
        send_cmd(crs_pkg::CmdAdd, '0, 49'h1_0000_0000_0000);
        send_cmd(crs_pkg::CmdQuery, 48'hFFFF_FFFF_FFFF, '0);
        send_cmd(crs_pkg::CmdAdd, 48'hFFFF_FFFF_FFFF, 49'd1);
        set_config(RegionMax, 64'hFFFF, 1'b0);
        send_cmd(crs_pkg::CmdAdd, 48'hFFFF_0000_0000, 49'h0_FFFF_0000_0000);
        send_cmd(crs_pkg::CmdQuery, 48'h0000_0001_0000, '0);
        send_cmd(crs_pkg::CmdQuery, 48'h0000_0000_8000, '0);
        drain();
    endtask

    task automatic test_random;
        logic [63:0] masks [4];
        logic [63:0] pages, pg, p, n;
        int phase_items;
        masks = '{64'd4095, 64'd0, 64'hFFFF, 64'd255};
        for (int ph = 0; ph < 13; ph++) begin
            if (ph == 5) begin
                set_config(RegionMax, 0, 1'b0);
            end else begin
                pg = masks[$urandom_range(0, 3)] + 1;
                pages = 64'($urandom_range(8, 200));
                set_config(pages * pg, pg - 1, ($urandom_range(0, 7) == 0));
            end
            add_pages(0, cfg_region / (cfg_mask + 1));
            pages = cfg_region / (cfg_mask + 1);
            phase_items = 42;
            if (ph == 3) begin
                hold_len = 600;
                hold_tog = ~hold_tog;
            end
            for (int it = 0; it < phase_items; it++) begin
                if (ph == 5 || $urandom_range(0, 9) == 0) begin
                    send_cmd(1'($urandom_range(0, 1)), 48'({$urandom, $urandom}),
                             49'(($urandom_range(0, 1) ? 64'h1_0000_0000_0000 : 64'd0) |
                                 ({$urandom, $urandom} >> $urandom_range(0, 63))));
                end else if ($urandom_range(0, 40) == 0) begin
                    add_pages(0, pages);
                end else begin
                    p = 64'($urandom_range(0, 32'(pages - 1)));
                    n = 64'($urandom_range(1, (pages - p) < 8 ? 32'(pages - p) : 8));
                    if ($urandom_range(0, 1)) add_pages(p, n);
                    else query_page(p);
                end
            end
            drain();
        end
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat status=%0d", $time, o_status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_status);
                    mismatches++;
                end
                if (o_committed !== want.committed) begin
                    $display("%0t: committed expected %0d actual %0d", $time,
                             want.committed, o_committed);
                    mismatches++;
                end
                if (o_run_size !== want.run_size) begin
                    $display("%0t: run_size expected %0h actual %0h", $time,
                             want.run_size, o_run_size);
                    mismatches++;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_cnt  <= hold_len;
            i_ready   <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready  <= 1'b0;
        end else begin
            if (mode_cnt == 0) ready_mode <= $urandom_range(0, 2);
            mode_cnt <= (mode_cnt + 1) % 97;
            case (ready_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("committed_range_interval_set test failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_table_full();
        test_edges();
        test_all_committed();
        test_wide_fields();
        test_random();
        drain();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("committed_range_interval_set test passed");
        end else begin
            $display("committed_range_interval_set test failed");
        end
        $finish;
    end

endmodule
